/* hw/rtl/indexed_min_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed min priority queue
// Same-cycle and next-cycle implication checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IMPQ_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("impq check failed");

// antecedent implies consequent in the next cycle
`define IMPQ_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("impq check failed");

`endif

/* hw/rtl/impq_pkg.sv */
// ----------------------------------------------------------------------------
// impq_pkg
// Types and constants shared by the indexed min priority queue.
// ----------------------------------------------------------------------------
package impq_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_WIDTH = 32;
    localparam int VERTICES  = 256;

    typedef logic signed [KEY_WIDTH-1:0] t_key;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DECREASE = 2'd1,
        OP_EXTRACT  = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [7:0]         vertex_id;
        logic signed [31:0] key_value;
    } t_in;

    typedef struct packed {
        t_status    status;
        logic [7:0] min_vertex;
        logic       in_heap;
        logic       heap_empty;
        logic [8:0] entry_count;
    } t_out;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_INSERT,
        CMD_DEC_START,
        CMD_DEC_POS,
        CMD_UP_RD,
        CMD_UP_PV,
        CMD_UP_MOVE,
        CMD_PLACE,
        CMD_EX_RD0,
        CMD_EX_ROOT,
        CMD_EX_LAST,
        CMD_EX_LKEY,
        CMD_DN_RDL,
        CMD_DN_LV,
        CMD_DN_LK,
        CMD_DN_RK,
        CMD_DN_MOVE_L,
        CMD_DN_MOVE_R,
        CMD_FINISH
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic present;
        logic full;
        logic cnt_zero;
        logic at_zero;
        logic left_ok;
        logic right_ok;
        logic up_less;
        logic dn_l;
        logic dn_r;
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/impq_ctrl.sv */
// ----------------------------------------------------------------------------
// impq_ctrl
// Operation sequencer: dispatch, sift up and sift down walks, result hand-off.
// ----------------------------------------------------------------------------
module impq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  impq_pkg::t_stat i_stat,
    output impq_pkg::t_cmd  o_cmd
);
    import impq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DEC_POS, S_UP_CHK, S_UP_PV, S_UP_PK,
        S_EX_ROOT, S_EX_LAST, S_EX_LKEY, S_DN_CHK, S_DN_LV, S_DN_LK,
        S_DN_RK, S_DN_SEL, S_FINISH
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_cmd_op n_op;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_op     = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = CMD_LATCH;
                    n_status = ST_OK;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    OP_INSERT: begin
                        priority if (i_stat.present) begin
                            n_status = ST_PRESENT;
                            n_state  = S_FINISH;
                        end else if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_FINISH;
                        end else begin
                            n_op    = CMD_INSERT;
                            n_state = S_UP_CHK;
                        end
                    end
                    OP_DECREASE: begin
                        if (!i_stat.present) begin
                            n_status = ST_ABSENT;
                            n_state  = S_FINISH;
                        end else begin
                            n_op    = CMD_DEC_START;
                            n_state = S_DEC_POS;
                        end
                    end
                    OP_EXTRACT: begin
                        if (i_stat.cnt_zero) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FINISH;
                        end else begin
                            n_op    = CMD_EX_RD0;
                            n_state = S_EX_ROOT;
                        end
                    end
                    OP_QUERY: n_state = S_FINISH;
                endcase
            end
            S_DEC_POS: begin
                n_op    = CMD_DEC_POS;
                n_state = S_UP_CHK;
            end
            S_UP_CHK: begin
                if (i_stat.at_zero) begin
                    n_op    = CMD_PLACE;
                    n_state = S_FINISH;
                end else begin
                    n_op    = CMD_UP_RD;
                    n_state = S_UP_PV;
                end
            end
            S_UP_PV: begin
                n_op    = CMD_UP_PV;
                n_state = S_UP_PK;
            end
            S_UP_PK: begin
                if (i_stat.up_less) begin
                    n_op    = CMD_UP_MOVE;
                    n_state = S_UP_CHK;
                end else begin
                    n_op    = CMD_PLACE;
                    n_state = S_FINISH;
                end
            end
            S_EX_ROOT: begin
                n_op    = CMD_EX_ROOT;
                n_state = S_EX_LAST;
            end
            S_EX_LAST: begin
                n_op    = CMD_EX_LAST;
                n_state = S_EX_LKEY;
            end
            S_EX_LKEY: begin
                n_op    = CMD_EX_LKEY;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (!i_stat.left_ok) begin
                    n_op    = CMD_PLACE;
                    n_state = S_FINISH;
                end else begin
                    n_op    = CMD_DN_RDL;
                    n_state = S_DN_LV;
                end
            end
            S_DN_LV: begin
                n_op    = CMD_DN_LV;
                n_state = S_DN_LK;
            end
            S_DN_LK: begin
                n_op    = CMD_DN_LK;
                n_state = i_stat.right_ok ? S_DN_RK : S_DN_SEL;
            end
            S_DN_RK: begin
                n_op    = CMD_DN_RK;
                n_state = S_DN_SEL;
            end
            S_DN_SEL: begin
                priority if (i_stat.dn_r) begin
                    n_op    = CMD_DN_MOVE_R;
                    n_state = S_DN_CHK;
                end else if (i_stat.dn_l) begin
                    n_op    = CMD_DN_MOVE_L;
                    n_state = S_DN_CHK;
                end else begin
                    n_op    = CMD_PLACE;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_op    = CMD_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.op     = n_op;
    assign o_cmd.status = r_status;

endmodule

/* hw/rtl/impq_datapath.sv */
// ----------------------------------------------------------------------------
// impq_datapath
// Heap, position and key memories, walk registers, key compares, result beat.
// ----------------------------------------------------------------------------
module impq_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  impq_pkg::t_in   i_in_data,
    input  impq_pkg::t_cmd  i_cmd,
    output impq_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output impq_pkg::t_out  o_out_data
);
    import impq_pkg::*;

    logic [7:0] r_heap_mem [VERTICES];
    logic [7:0] r_pos_mem  [VERTICES];
    t_key       r_key_mem  [VERTICES];

    logic [7:0] r_heap_rd, r_pos_rd;
    t_key       r_key_rd;

    t_in        r_in;
    logic [7:0] r_at, r_cv, r_pv, r_lv, r_rv, r_root;
    t_key       r_ck, r_lk, r_rk;
    logic [8:0] r_cnt;
    logic       r_present [VERTICES];
    t_out       r_out;
    logic       r_ov;

    logic       heap_we, key_we, pos_we;
    logic [7:0] heap_wa, heap_wd, heap_ra, key_wa, key_ra, pos_ra;
    t_key       key_wd;
    t_key       in_key;
    logic [7:0] parent;
    logic [8:0] left;
    logic [9:0] right;
    logic       dn_l;

    assign in_key = t_key'(r_in.key_value);
    assign parent = 8'((r_at - 8'd1) >> 1);
    assign left   = {r_at, 1'b1};
    assign right  = {1'b0, left} + 10'd1;
    assign dn_l   = r_lk < r_ck;

    assign o_stat.op       = r_in.operation;
    assign o_stat.present  = r_present[r_in.vertex_id];
    assign o_stat.full     = 32'(r_cnt) >= CAPACITY;
    assign o_stat.cnt_zero = (r_cnt == 9'd0);
    assign o_stat.at_zero  = (r_at == 8'd0);
    assign o_stat.left_ok  = left < r_cnt;
    assign o_stat.right_ok = right < {1'b0, r_cnt};
    assign o_stat.up_less  = r_ck < r_key_rd;
    assign o_stat.dn_l     = dn_l;
    assign o_stat.dn_r     = (right < {1'b0, r_cnt}) && (r_rk < (dn_l ? r_lk : r_ck));
    assign o_stat.out_free = !r_ov || i_out_ready;

    always_comb begin
        heap_we = 1'b0;
        heap_wa = r_at;
        heap_wd = r_cv;
        heap_ra = 8'd0;
        key_we  = 1'b0;
        key_wa  = r_in.vertex_id;
        key_wd  = in_key;
        key_ra  = r_heap_rd;
        pos_we  = 1'b0;
        pos_ra  = r_in.vertex_id;
        unique case (i_cmd.op)
            CMD_INSERT,
            CMD_DEC_START: key_we = 1'b1;
            CMD_UP_RD:     heap_ra = parent;
            CMD_UP_MOVE: begin
                heap_we = 1'b1;
                heap_wd = r_pv;
                pos_we  = 1'b1;
            end
            CMD_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            CMD_EX_ROOT:   heap_ra = 8'(r_cnt - 9'd1);
            CMD_DN_RDL:    heap_ra = left[7:0];
            CMD_DN_LV:     heap_ra = right[7:0];
            CMD_DN_MOVE_L: begin
                heap_we = 1'b1;
                heap_wd = r_lv;
                pos_we  = 1'b1;
            end
            CMD_DN_MOVE_R: begin
                heap_we = 1'b1;
                heap_wd = r_rv;
                pos_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            r_heap_mem[heap_wa] <= heap_wd;
        end
        if (pos_we) begin
            r_pos_mem[heap_wd] <= heap_wa;
        end
        if (key_we) begin
            r_key_mem[key_wa] <= key_wd;
        end
        r_heap_rd <= r_heap_mem[heap_ra];
        r_pos_rd  <= r_pos_mem[pos_ra];
        r_key_rd  <= r_key_mem[key_ra];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LATCH: r_in <= i_in_data;
            CMD_INSERT: begin
                r_at <= r_cnt[7:0];
                r_cv <= r_in.vertex_id;
                r_ck <= in_key;
            end
            CMD_DEC_START: begin
                r_cv <= r_in.vertex_id;
                r_ck <= in_key;
            end
            CMD_DEC_POS:   r_at <= r_pos_rd;
            CMD_UP_PV:     r_pv <= r_heap_rd;
            CMD_UP_MOVE:   r_at <= parent;
            CMD_EX_ROOT:   r_root <= r_heap_rd;
            CMD_EX_LAST:   r_cv <= r_heap_rd;
            CMD_EX_LKEY: begin
                r_ck <= r_key_rd;
                r_at <= 8'd0;
            end
            CMD_DN_LV:     r_lv <= r_heap_rd;
            CMD_DN_LK: begin
                r_lk <= r_key_rd;
                r_rv <= r_heap_rd;
            end
            CMD_DN_RK:     r_rk <= r_key_rd;
            CMD_DN_MOVE_L: r_at <= left[7:0];
            CMD_DN_MOVE_R: r_at <= right[7:0];
            CMD_FINISH: begin
                r_out.status      <= i_cmd.status;
                r_out.min_vertex  <= (r_in.operation == OP_EXTRACT && i_cmd.status == ST_OK)
                                     ? r_root : 8'd0;
                r_out.in_heap     <= (r_in.operation == OP_QUERY) && r_present[r_in.vertex_id];
                r_out.heap_empty  <= (r_cnt == 9'd0);
                r_out.entry_count <= r_cnt;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 9'd0;
            r_ov  <= 1'b0;
            for (int i = 0; i < VERTICES; i++) begin
                r_present[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.op == CMD_INSERT) begin
                r_cnt <= r_cnt + 9'd1;
                r_present[r_in.vertex_id] <= 1'b1;
            end else if (i_cmd.op == CMD_EX_ROOT) begin
                r_cnt <= r_cnt - 9'd1;
                r_present[r_heap_rd] <= 1'b0;
            end
            if (i_cmd.op == CMD_FINISH) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/indexed_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// indexed_min_priority_queue
// Indexed binary min-heap of vertex ids with insert, decrease-key,
// extract-min and membership query.
//
// One input beat is one operation; exactly one result beat follows it.
// The input channel takes a beat only while no operation is in progress.
// Query and rejected operations finish straight from dispatch; insert and
// decrease climb the heap level by level, and extract descends it level
// by level (at most 7 levels), each sift loop being bound by the single
// read port of each memory.
// The result sits in an output register; while the receiver stalls the
// next operation is still accepted and run, and waits only to hand over.
// Reset empties the heap and marks all vertices absent at once; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  impq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output impq_pkg::t_out o_out_data
);
    import impq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    impq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    impq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/impq_checker.sv */
// ----------------------------------------------------------------------------
// impq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`include "indexed_min_priority_queue_assert.svh"

module impq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input impq_pkg::t_out o_out_data
);
    import impq_pkg::*;

    `IMPQ_CHECK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `IMPQ_CHECK(a_empty_flag, o_out_valid, o_out_data.heap_empty == (o_out_data.entry_count == 9'd0))
    `IMPQ_CHECK(a_reject_clean, o_out_valid && o_out_data.status != ST_OK, o_out_data.min_vertex == 8'd0 && !o_out_data.in_heap)
    `IMPQ_CHECK(a_empty_count, o_out_valid && o_out_data.status == ST_EMPTY, o_out_data.entry_count == 9'd0)

endmodule

bind indexed_min_priority_queue impq_checker u_impq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
